// ===== rtl/itoa_pkg.sv =====
package itoa_pkg;

   // default configuration
   localparam int VALUE_BITS_DEF = 32;
   localparam int MAX_FIELD_DEF  = 63;

   // fixed field widths
   localparam int RADIX_W  = 6;
   localparam int WIDTH_W  = 6;
   localparam int DIGITS_W = 6;
   localparam int FLAGS_W  = 7;
   localparam int CHAR_W   = 8;

   // quotient bits resolved per divider cycle
   localparam int DIV_STEPS = 8;

   // format flag bit positions
   localparam int FLAG_ZERO   = 0;
   localparam int FLAG_SIGNED = 1;
   localparam int FLAG_PLUS   = 2;
   localparam int FLAG_SPACE  = 3;
   localparam int FLAG_LEFT   = 4;
   localparam int FLAG_PREFIX = 5;
   localparam int FLAG_LOWER  = 6;

   // base limits and prefixed bases
   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
   localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

   typedef logic [CHAR_W-1:0] char_type;

   // ascii codes
   localparam char_type CH_NUL   = 8'h00;
   localparam char_type CH_SPACE = 8'h20;
   localparam char_type CH_PLUS  = 8'h2B;
   localparam char_type CH_MINUS = 8'h2D;
   localparam char_type CH_ZERO  = 8'h30;
   localparam char_type CH_A_UP  = 8'h41;
   localparam char_type CH_A_LOW = 8'h61;
   localparam char_type CH_X_UP  = 8'h58;
   localparam char_type CH_X_LOW = 8'h78;

   // sequencer states: digit generation, field sizing, then one state per segment
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_CALC_A,
      ST_CALC_B,
      ST_LEAD,
      ST_SIGN,
      ST_PRE0,
      ST_PREX,
      ST_ZPAD,
      ST_PZERO,
      ST_DIGIT,
      ST_TRAIL,
      ST_ERR
   } seq_state_type;

   // one character handed from the sequencer to the output register
   typedef struct packed {
      logic     valid;
      char_type character;
      logic     last;
      logic     error;
   } emit_type;

   // digit value 0..35 to its ascii character
   function automatic char_type digit_char(input logic [RADIX_W-1:0] digit, input logic lower);
      char_type alpha;
      alpha = lower ? CH_A_LOW : CH_A_UP;
      if (digit < 6'd10) begin
         return CH_ZERO + CHAR_W'(digit);
      end
      return alpha + CHAR_W'(digit - 6'd10);
   endfunction

endpackage

// ===== rtl/itoa_req_if.sv =====
interface itoa_req_if #(
   parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
);
   logic                            valid;
   logic                            ready;
   logic [VALUE_BITS-1:0]           value;
   logic [itoa_pkg::RADIX_W-1:0]    radix;
   logic [itoa_pkg::WIDTH_W-1:0]    width;
   logic [itoa_pkg::DIGITS_W-1:0]   min_digits;
   logic [itoa_pkg::FLAGS_W-1:0]    format_flags;

   modport source (output valid, value, radix, width, min_digits, format_flags, input ready);
   modport sink   (input valid, value, radix, width, min_digits, format_flags, output ready);
endinterface

// ===== rtl/itoa_rsp_if.sv =====
interface itoa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [itoa_pkg::CHAR_W-1:0]  character;
   logic                         last;
   logic                         error;

   modport source (output valid, character, last, error, input ready);
   modport sink   (input valid, character, last, error, output ready);
endinterface

// ===== rtl/itoa_div.sv =====
module itoa_div #(
   parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [VALUE_BITS-1:0]          dividend,
   input  logic [itoa_pkg::RADIX_W-1:0]   radix,
   output logic                           done,
   output logic [VALUE_BITS-1:0]          quotient,
   output logic [itoa_pkg::RADIX_W-1:0]   remainder
);
   import itoa_pkg::*;

   localparam int DIV_W   = ((VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS) * DIV_STEPS;
   localparam int DIV_CYC = DIV_W / DIV_STEPS;
   localparam int CYC_W   = $clog2(DIV_CYC + 1);

   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [RADIX_W-1:0] rem_ff, rem_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic [CYC_W-1:0]   cyc_ff, cyc_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [DIV_W-1:0]   quo_step;
   logic [RADIX_W-1:0] rem_step;
   logic [RADIX_W:0]   partial;

   // restoring division, several quotient bits per cycle on a narrow remainder
   always_comb begin
      quo_step = quo_ff;
      rem_step = rem_ff;
      partial  = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         partial  = {rem_step, quo_step[DIV_W-1]};
         quo_step = {quo_step[DIV_W-2:0], 1'b0};
         if (partial >= {1'b0, radix_ff}) begin
            partial     = partial - {1'b0, radix_ff};
            quo_step[0] = 1'b1;
         end
         rem_step = partial[RADIX_W-1:0];
      end
   end

   // load on start, then step until all bits are consumed
   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      cyc_in   = cyc_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         quo_in   = DIV_W'(dividend);
         rem_in   = '0;
         radix_in = radix;
         cyc_in   = CYC_W'(DIV_CYC);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         quo_in = quo_step;
         rem_in = rem_step;
         cyc_in = cyc_ff - 1'b1;
         if (cyc_ff == CYC_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
      cyc_ff   <= cyc_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff[VALUE_BITS-1:0];
   assign remainder = rem_ff;

endmodule

// ===== rtl/itoa_seq.sv =====
module itoa_seq #(
   parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF,
   parameter int MAX_FIELD  = itoa_pkg::MAX_FIELD_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   itoa_req_if.sink                       req_bus,
   input  logic                           out_free,
   output itoa_pkg::emit_type             emit,
   output logic                           div_start,
   output logic [VALUE_BITS-1:0]          div_dividend,
   output logic [itoa_pkg::RADIX_W-1:0]   div_radix,
   input  logic                           div_done,
   input  logic [VALUE_BITS-1:0]          div_quotient,
   input  logic [itoa_pkg::RADIX_W-1:0]   div_remainder
);
   import itoa_pkg::*;

   localparam int LEN_W = $clog2(MAX_FIELD + VALUE_BITS + 4);

   seq_state_type      state_ff, state_in;
   logic [RADIX_W-1:0] radix_ff, radix_in;
   logic               lower_ff, lower_in;
   logic               left_ff, left_in;
   logic               zero_ff, zero_in;
   char_type           sign_ch_ff, sign_ch_in;
   logic               sl_ff, sl_in;
   logic [1:0]         pl_ff, pl_in;
   logic [LEN_W-1:0]   fw_ff, fw_in;
   logic [LEN_W-1:0]   prec_ff, prec_in;
   logic [LEN_W-1:0]   nd_ff, nd_in;
   logic [LEN_W-1:0]   pad_ff, pad_in;
   logic [LEN_W-1:0]   total_ff, total_in;
   logic [LEN_W-1:0]   pos_ff, pos_in;
   logic [LEN_W-1:0]   cnt_ff, cnt_in;
   logic [RADIX_W-1:0] stack_ff [VALUE_BITS];
   logic [RADIX_W-1:0] stack_in [VALUE_BITS];

   logic               accept;
   logic               radix_ok;
   logic               negative;
   logic [VALUE_BITS-1:0] magnitude;
   logic [LEN_W-1:0]   seg_len;
   logic               fire;
   logic               seg_done;
   logic               is_last;
   logic               push;
   logic               pop;
   logic [LEN_W-1:0]   lim;
   logic [LEN_W-1:0]   prec_max;
   logic [LEN_W-1:0]   body;
   logic [LEN_W-1:0]   field;

   // request side
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign radix_ok      = (req_bus.radix >= RADIX_MIN) && (req_bus.radix <= RADIX_MAX);
   assign negative      = req_bus.format_flags[FLAG_SIGNED] && req_bus.value[VALUE_BITS-1];
   assign magnitude     = negative ? (VALUE_BITS'(0) - req_bus.value) : req_bus.value;

   // length of the segment the sequencer is in
   always_comb begin
      unique case (state_ff)
         ST_LEAD:  seg_len = (!zero_ff && !left_ff) ? pad_ff : '0;
         ST_SIGN:  seg_len = LEN_W'(sl_ff);
         ST_PRE0:  seg_len = LEN_W'(pl_ff != 2'd0);
         ST_PREX:  seg_len = LEN_W'(pl_ff == 2'd2);
         ST_ZPAD:  seg_len = zero_ff ? pad_ff : '0;
         ST_PZERO: seg_len = prec_ff - nd_ff;
         ST_DIGIT: seg_len = nd_ff;
         ST_TRAIL: seg_len = left_ff ? pad_ff : '0;
         default:  seg_len = '0;
      endcase
   end

   // one character per cycle while the output slot is free
   assign fire     = (state_ff == ST_ERR) ? out_free : ((pos_ff != seg_len) && out_free);
   assign seg_done = (pos_ff == seg_len) || (fire && (pos_ff + 1'b1 == seg_len));
   assign is_last  = (cnt_ff == total_ff - 1'b1);
   assign push     = (state_ff == ST_DIV) && div_done;
   assign pop      = (state_ff == ST_DIGIT) && fire;

   // field sizing
   assign lim      = LEN_W'(MAX_FIELD) - LEN_W'(sl_ff) - LEN_W'(pl_ff);
   assign prec_max = (prec_ff < nd_ff) ? nd_ff : prec_ff;
   assign body     = LEN_W'(sl_ff) + LEN_W'(pl_ff) + prec_ff;
   assign field    = (fw_ff > body) ? fw_ff : body;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = radix_ok ? ST_DIV : ST_ERR;
            end
         end
         ST_DIV: begin
            if (div_done && (div_quotient == '0)) begin
               state_in = ST_CALC_A;
            end
         end
         ST_CALC_A: state_in = ST_CALC_B;
         ST_CALC_B: state_in = ST_LEAD;
         ST_ERR: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            if (fire && is_last) begin
               state_in = ST_IDLE;
            end else if (seg_done) begin
               unique case (state_ff)
                  ST_LEAD:  state_in = ST_SIGN;
                  ST_SIGN:  state_in = ST_PRE0;
                  ST_PRE0:  state_in = ST_PREX;
                  ST_PREX:  state_in = ST_ZPAD;
                  ST_ZPAD:  state_in = ST_PZERO;
                  ST_PZERO: state_in = ST_DIGIT;
                  ST_DIGIT: state_in = ST_TRAIL;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
      endcase
   end

   // outputs: divider commands and the character for this cycle
   always_comb begin
      div_start      = 1'b0;
      div_dividend   = magnitude;
      div_radix      = req_bus.radix;
      emit.valid     = 1'b0;
      emit.character = CH_NUL;
      emit.last      = is_last;
      emit.error     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            div_start = accept && radix_ok;
         end
         ST_DIV: begin
            div_dividend = div_quotient;
            div_radix    = radix_ff;
            div_start    = div_done && (div_quotient != '0);
         end
         ST_CALC_A, ST_CALC_B: begin
            div_start = 1'b0;
         end
         ST_ERR: begin
            emit.valid = fire;
            emit.last  = 1'b1;
            emit.error = 1'b1;
         end
         default: begin
            emit.valid = fire;
            unique case (state_ff)
               ST_SIGN:  emit.character = sign_ch_ff;
               ST_PRE0:  emit.character = CH_ZERO;
               ST_PREX:  emit.character = lower_ff ? CH_X_LOW : CH_X_UP;
               ST_ZPAD:  emit.character = CH_ZERO;
               ST_PZERO: emit.character = CH_ZERO;
               ST_DIGIT: emit.character = digit_char(stack_ff[0], lower_ff);
               default:  emit.character = CH_SPACE;
            endcase
         end
      endcase
   end

   // datapath next values
   always_comb begin
      radix_in   = radix_ff;
      lower_in   = lower_ff;
      left_in    = left_ff;
      zero_in    = zero_ff;
      sign_ch_in = sign_ch_ff;
      sl_in      = sl_ff;
      pl_in      = pl_ff;
      fw_in      = fw_ff;
      prec_in    = prec_ff;
      nd_in      = nd_ff;
      pad_in     = pad_ff;
      total_in   = total_ff;
      pos_in     = pos_ff;
      cnt_in     = cnt_ff;

      // capture the item and work out sign and prefix
      if (accept) begin
         radix_in = req_bus.radix;
         lower_in = req_bus.format_flags[FLAG_LOWER];
         left_in  = req_bus.format_flags[FLAG_LEFT];
         zero_in  = req_bus.format_flags[FLAG_ZERO] && !req_bus.format_flags[FLAG_LEFT];
         sl_in    = 1'b1;
         if (negative) begin
            sign_ch_in = CH_MINUS;
         end else if (req_bus.format_flags[FLAG_PLUS]) begin
            sign_ch_in = CH_PLUS;
         end else if (req_bus.format_flags[FLAG_SPACE]) begin
            sign_ch_in = CH_SPACE;
         end else begin
            sign_ch_in = CH_NUL;
            sl_in      = 1'b0;
         end
         pl_in = 2'd0;
         if (req_bus.format_flags[FLAG_PREFIX]) begin
            if (req_bus.radix == RADIX_HEX) begin
               pl_in = 2'd2;
            end else if (req_bus.radix == RADIX_OCT) begin
               pl_in = 2'd1;
            end
         end
         fw_in   = (LEN_W'(req_bus.width) > LEN_W'(MAX_FIELD)) ?
                   LEN_W'(MAX_FIELD) : LEN_W'(req_bus.width);
         prec_in = LEN_W'(req_bus.min_digits);
         nd_in   = '0;
         pos_in  = '0;
         cnt_in  = '0;
      end

      // digit count
      if (push) begin
         nd_in = nd_ff + 1'b1;
      end

      // precision after the digit count and the field limit
      if (state_ff == ST_CALC_A) begin
         prec_in = (prec_max > lim) ? ((nd_ff > lim) ? nd_ff : lim) : prec_max;
      end

      // padding and run length
      if (state_ff == ST_CALC_B) begin
         pad_in   = field - body;
         total_in = (field > LEN_W'(MAX_FIELD)) ? LEN_W'(MAX_FIELD) : field;
         pos_in   = '0;
      end

      // segment position and character count
      if (state_ff inside {ST_LEAD, ST_SIGN, ST_PRE0, ST_PREX, ST_ZPAD, ST_PZERO, ST_DIGIT,
                           ST_TRAIL}) begin
         if (seg_done) begin
            pos_in = '0;
         end else if (fire) begin
            pos_in = pos_ff + 1'b1;
         end
         if (fire) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   // digit stack: pushed least significant first, popped most significant first
   always_comb begin
      for (int i = 0; i < VALUE_BITS; i++) begin
         stack_in[i] = stack_ff[i];
      end
      if (push) begin
         stack_in[0] = div_remainder;
         for (int i = 1; i < VALUE_BITS; i++) begin
            stack_in[i] = stack_ff[i-1];
         end
      end else if (pop) begin
         for (int i = 0; i < VALUE_BITS - 1; i++) begin
            stack_in[i] = stack_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      radix_ff   <= radix_in;
      lower_ff   <= lower_in;
      left_ff    <= left_in;
      zero_ff    <= zero_in;
      sign_ch_ff <= sign_ch_in;
      sl_ff      <= sl_in;
      pl_ff      <= pl_in;
      fw_ff      <= fw_in;
      prec_ff    <= prec_in;
      nd_ff      <= nd_in;
      pad_ff     <= pad_in;
      total_ff   <= total_in;
      pos_ff     <= pos_in;
      cnt_ff     <= cnt_in;
      for (int i = 0; i < VALUE_BITS; i++) begin
         stack_ff[i] <= stack_in[i];
      end
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// Integer to ASCII formatter: printf-style conversion of one value per item.
// req_bus carries value, radix, width, min_digits and format_flags; an item is
// taken when valid and ready are both high. rsp_bus returns the formatted text
// one character per transfer, with last on the final character; a radix outside
// 2 to 36 gives a single NUL character with last and error set.
// One item at a time: ready is high only while the sequencer is idle.
// Digits come from one shared divider that resolves 8 quotient bits a cycle;
// once all digits are generated, the characters follow one per cycle while
// the receiver keeps ready high, the sequencer also stepping through each
// empty segment of the field; at most MAX_FIELD characters per item.
// The output register holds each character until the receiver takes it; when
// the receiver holds ready low the sequencer waits with it, nothing is lost.
// Synchronous reset returns the sequencer to idle, stops the divider and empties
// the output register; the datapath registers are not reset.
module integer_to_ascii_formatter #(
   parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF,
   parameter int MAX_FIELD  = itoa_pkg::MAX_FIELD_DEF
) (
   input  logic        clock,
   input  logic        reset,
   itoa_req_if.sink    req_bus,
   itoa_rsp_if.source  rsp_bus
);
   import itoa_pkg::*;

   emit_type              emit;
   logic                  out_free;
   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   logic [RADIX_W-1:0]    div_radix;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quotient;
   logic [RADIX_W-1:0]    div_remainder;

   logic                  out_valid_ff, out_valid_in;
   char_type              out_char_ff, out_char_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_error_ff, out_error_in;

   // shared digit divider
   itoa_div #(
      .VALUE_BITS (VALUE_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .radix     (div_radix),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // sequencer and digit stack
   itoa_seq #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_FIELD  (MAX_FIELD)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .out_free      (out_free),
      .emit          (emit),
      .div_start     (div_start),
      .div_dividend  (div_dividend),
      .div_radix     (div_radix),
      .div_done      (div_done),
      .div_quotient  (div_quotient),
      .div_remainder (div_remainder)
   );

   // output register
   assign out_free = !out_valid_ff || rsp_bus.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_error_in = out_error_ff;
      if (emit.valid) begin
         out_valid_in = 1'b1;
         out_char_in  = emit.character;
         out_last_in  = emit.last;
         out_error_in = emit.error;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_char_ff  <= out_char_in;
      out_last_ff  <= out_last_in;
      out_error_ff <= out_error_in;
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.character = out_char_ff;
   assign rsp_bus.last      = out_last_ff;
   assign rsp_bus.error     = out_error_ff;

`ifndef SYNTHESIS
   // a new character never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> out_free)
      else $error("character loaded while output register is held");

   // an accepted item keeps the block busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("ready stayed high after an item was accepted");

   // an error result is a lone NUL marked last
   a_error_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.error) |-> (rsp_bus.last && (rsp_bus.character == CH_NUL)))
      else $error("error result is not a single NUL character");
`endif

endmodule

// ===== tb/tb.sv =====
module tb;
   import itoa_pkg::*;

   localparam int VB        = VALUE_BITS_DEF;
   localparam int MAX_FIELD = MAX_FIELD_DEF;
   localparam int X_INDEX   = 33;
   localparam string UPPER_SET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
   localparam string LOWER_SET = "0123456789abcdefghijklmnopqrstuvwxyz";

   // flag masks
   localparam logic [FLAGS_W-1:0] F_ZERO   = FLAGS_W'(1 << FLAG_ZERO);
   localparam logic [FLAGS_W-1:0] F_SIGNED = FLAGS_W'(1 << FLAG_SIGNED);
   localparam logic [FLAGS_W-1:0] F_PLUS   = FLAGS_W'(1 << FLAG_PLUS);
   localparam logic [FLAGS_W-1:0] F_SPACE  = FLAGS_W'(1 << FLAG_SPACE);
   localparam logic [FLAGS_W-1:0] F_LEFT   = FLAGS_W'(1 << FLAG_LEFT);
   localparam logic [FLAGS_W-1:0] F_PREFIX = FLAGS_W'(1 << FLAG_PREFIX);
   localparam logic [FLAGS_W-1:0] F_LOWER  = FLAGS_W'(1 << FLAG_LOWER);
   localparam logic [FLAGS_W-1:0] F_ALL    = '1;

   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 146;

   typedef struct packed {
      logic [VB-1:0]       value;
      logic [RADIX_W-1:0]  radix;
      logic [WIDTH_W-1:0]  width;
      logic [DIGITS_W-1:0] min_digits;
      logic [FLAGS_W-1:0]  format_flags;
   } request_type;

   typedef struct packed {
      char_type character;
      logic     last;
      logic     error;
   } char_item_type;

   // expected text of each accepted request, checked character by character
   class format_scoreboard;
      char_item_type expected_chars[$];
      int errors;
      int checked;

      task report_mismatch(input string what);
         $display("mismatch at character %0d: %s", checked, what);
         errors++;
      endtask

      // formats one request into the characters it should produce
      task note_request(input request_type r);
         logic [VB-1:0]      mag;
         logic [FLAGS_W-1:0] fl;
         string              digit_set;
         char_type           sign_ch;
         char_type           digs[$];
         char_type           text[$];
         char_item_type      e;
         int                 sl, pl, nd, fw, prec, lim, pad, n;
         if (r.radix < RADIX_MIN || r.radix > RADIX_MAX) begin
            e.character = CH_NUL;
            e.last = 1'b1;
            e.error = 1'b1;
            expected_chars.push_back(e);
            return;
         end
         fl = r.format_flags;
         // left justify cancels zero padding
         if (fl[FLAG_LEFT]) begin
            fl[FLAG_ZERO] = 1'b0;
         end
         digit_set = fl[FLAG_LOWER] ? LOWER_SET : UPPER_SET;
         mag = r.value;
         sign_ch = CH_NUL;
         if (fl[FLAG_SIGNED] && mag[VB-1]) begin
            sign_ch = CH_MINUS;
            mag = -mag;
         end else if (fl[FLAG_PLUS]) begin
            sign_ch = CH_PLUS;
         end else if (fl[FLAG_SPACE]) begin
            sign_ch = CH_SPACE;
         end
         sl = (sign_ch != CH_NUL) ? 1 : 0;
         pl = 0;
         if (fl[FLAG_PREFIX]) begin
            pl = (r.radix == RADIX_HEX) ? 2 : ((r.radix == RADIX_OCT) ? 1 : 0);
         end
         // digits, least significant first
         do begin
            digs.push_back(digit_set[mag % r.radix]);
            mag = mag / r.radix;
         end while (mag != 0);
         nd = digs.size();
         // field sizing with clamps
         fw = r.width;
         if (fw > MAX_FIELD) begin
            fw = MAX_FIELD;
         end
         prec = r.min_digits;
         if (prec < nd) begin
            prec = nd;
         end
         lim = MAX_FIELD - sl - pl;
         if (prec > lim) begin
            prec = (nd > lim) ? nd : lim;
         end
         pad = fw - (sl + pl + prec);
         if (pad < 0) begin
            pad = 0;
         end
         // assemble the field segment by segment
         if (!fl[FLAG_ZERO] && !fl[FLAG_LEFT]) begin
            repeat (pad) text.push_back(CH_SPACE);
         end
         if (sl != 0) begin
            text.push_back(sign_ch);
         end
         if (pl >= 1) begin
            text.push_back(CH_ZERO);
         end
         if (pl == 2) begin
            text.push_back(digit_set[X_INDEX]);
         end
         if (fl[FLAG_ZERO]) begin
            repeat (pad) text.push_back(CH_ZERO);
         end
         repeat (prec - nd) text.push_back(CH_ZERO);
         for (int k = nd - 1; k >= 0; k--) begin
            text.push_back(digs[k]);
         end
         if (fl[FLAG_LEFT]) begin
            repeat (pad) text.push_back(CH_SPACE);
         end
         n = (text.size() > MAX_FIELD) ? MAX_FIELD : text.size();
         for (int k = 0; k < n; k++) begin
            e.character = text[k];
            e.last = (k == n - 1);
            e.error = 1'b0;
            expected_chars.push_back(e);
         end
      endtask

      task check_char(input char_item_type got);
         char_item_type want;
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character %h", got.character));
            return;
         end
         want = expected_chars.pop_front();
         if (got.character !== want.character) begin
            report_mismatch($sformatf("character got %h want %h",
                                      got.character, want.character));
         end
         if (got.last !== want.last) begin
            report_mismatch($sformatf("last got %b want %b", got.last, want.last));
         end
         if (got.error !== want.error) begin
            report_mismatch($sformatf("error got %b want %b", got.error, want.error));
         end
         checked++;
      endtask

      task check_drained();
         if (expected_chars.size() != 0) begin
            report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
         end
      endtask

      function int pending();
         return expected_chars.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_idle_on = 1'b0;
   logic rsp_idle_on = 1'b0;
   int   hold_cycles = 0;
   format_scoreboard text_board = new();

   itoa_req_if #(.VALUE_BITS(VB)) req_bus ();
   itoa_rsp_if rsp_bus ();

   integer_to_ascii_formatter #(
      .VALUE_BITS (VB),
      .MAX_FIELD  (MAX_FIELD)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #2 clock = ~clock;

   function automatic request_type make_request(input logic [VB-1:0] value,
                                                input int radix, input int width,
                                                input int min_digits,
                                                input logic [FLAGS_W-1:0] flags);
      request_type r;
      r.value = value;
      r.radix = RADIX_W'(radix);
      r.width = WIDTH_W'(width);
      r.min_digits = DIGITS_W'(min_digits);
      r.format_flags = flags;
      return r;
   endfunction

   // random request biased toward common bases and short fields
   function automatic request_type random_request();
      logic [VB-1:0] v;
      int pick, radix, width, min_digits;
      pick = $urandom_range(9);
      case (pick)
         0: v = '0;
         1: v = {1'b1, {(VB-1){1'b0}}};
         2: v = '1;
         3: v = {1'b0, {(VB-1){1'b1}}};
         4, 5: v = VB'($urandom_range(999));
         default: v = VB'($urandom());
      endcase
      pick = $urandom_range(99);
      if (pick < 10) begin
         radix = $urandom_range(1) ? $urandom_range(1) : $urandom_range(63, 37);
      end else if (pick < 30) begin
         radix = 10;
      end else if (pick < 45) begin
         radix = RADIX_HEX;
      end else if (pick < 55) begin
         radix = RADIX_OCT;
      end else if (pick < 65) begin
         radix = RADIX_MIN;
      end else begin
         radix = $urandom_range(RADIX_MAX, RADIX_MIN);
      end
      width = ($urandom_range(99) < 70) ? $urandom_range(20) : $urandom_range(63);
      pick = $urandom_range(99);
      if (pick < 60) begin
         min_digits = 0;
      end else if (pick < 85) begin
         min_digits = $urandom_range(12);
      end else begin
         min_digits = $urandom_range(60);
      end
      return make_request(v, radix, width, min_digits, FLAGS_W'($urandom_range(127)));
   endfunction

   // offer one item and hold it until the block takes it
   task automatic send_item(input request_type r);
      req_bus.valid <= 1'b1;
      req_bus.value <= r.value;
      req_bus.radix <= r.radix;
      req_bus.width <= r.width;
      req_bus.min_digits <= r.min_digits;
      req_bus.format_flags <= r.format_flags;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      text_board.note_request(r);
   endtask

   // random gaps on the request side
   task automatic idle_gaps();
      while (req_idle_on && $urandom_range(99) < 29) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (text_board.pending() != 0) @(posedge clock);
   endtask

   // result side: check accepted characters, then pick next ready
   initial begin : rsp_side
      char_item_type got;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.character = rsp_bus.character;
            got.last = rsp_bus.last;
            got.error = rsp_bus.error;
            text_board.check_char(got);
         end
         if (hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
         end else if (rsp_idle_on) begin
            rsp_bus.ready <= ($urandom_range(99) >= 29);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // request side: directed cases, then random items
   initial begin : req_side
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.value <= '0;
      req_bus.radix <= '0;
      req_bus.width <= '0;
      req_bus.min_digits <= '0;
      req_bus.format_flags <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed corners, back to back
      send_item(make_request(32'd0, 10, 0, 0, '0));
      send_item(make_request(32'hFFFF_FFFF, RADIX_MIN, 63, 0, '0));
      send_item(make_request(32'h8000_0000, 10, 0, 0, F_SIGNED));
      send_item(make_request(32'h7FFF_FFFF, 10, 15, 0, F_SIGNED | F_PLUS));
      send_item(make_request(32'd0, RADIX_HEX, 0, 0, F_PREFIX));
      send_item(make_request(32'd8, RADIX_OCT, 6, 0, F_PREFIX | F_ZERO));
      send_item(make_request(32'd0, RADIX_OCT, 0, 0, F_PREFIX));
      // bad bases
      send_item(make_request(32'd123, 0, 5, 0, '0));
      send_item(make_request(32'd123, 1, 5, 3, F_PLUS));
      send_item(make_request(32'd123, RADIX_MAX + 1, 0, 0, '0));
      send_item(make_request(32'hFFFF_FFFF, 63, 63, 60, F_ALL));
      // highest base, both letter cases
      send_item(make_request(32'hFFFF_FFFF, RADIX_MAX, 0, 0, F_LOWER));
      send_item(make_request(32'd35, RADIX_MAX, 0, 0, '0));
      // sign, prefix and padding interplay
      send_item(make_request(-32'sd123, RADIX_HEX, 20, 0, F_SIGNED | F_PREFIX | F_ZERO));
      send_item(make_request(-32'sd123, 10, 20, 0, F_SIGNED | F_LEFT | F_ZERO));
      send_item(make_request(32'd42, 10, 8, 0, F_SPACE));
      send_item(make_request(32'd42, 10, 8, 0, F_PLUS | F_SPACE));
      // precision clamped so sign, prefix and digits fill the whole field
      send_item(make_request(32'hFFFF_FFFF, RADIX_HEX, 63, 60, F_SIGNED | F_PREFIX));
      send_item(make_request(32'hFFFF_FFFF, RADIX_HEX, 63, 60,
                             F_SIGNED | F_PREFIX | F_LEFT | F_LOWER));
      send_item(make_request(32'h8000_0000, RADIX_MIN, 63, 60,
                             F_SIGNED | F_PREFIX | F_ZERO));
      send_item(make_request(-32'sd200, RADIX_HEX, 40, 10, F_ALL));
      send_item(make_request(32'hDEAD_BEEF, RADIX_HEX, 5, 0, F_PREFIX | F_LOWER));
      send_item(make_request(32'd123, 10, 63, 0, F_ZERO));
      send_item(make_request(32'd7, 10, 0, 60, '0));
      wait_drained();

      // random part with a quiet stretch, a long receiver hold and a pause
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         req_idle_on = !(i >= 60 && i < 100);
         rsp_idle_on = !(i >= 60 && i < 100);
         if (i == 110) begin
            hold_cycles <= HOLD_CYCLES;
         end
         if (i == 140) begin
            wait_drained();
         end
         idle_gaps();
         send_item(random_request());
      end
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (text_board.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      text_board.check_drained();
      if (text_board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // hang guard
   initial begin : watchdog
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
